// ----- hw/rtl/bpa_pkg.sv -----
// Shared constants and codes of the buddy page allocator.
`default_nettype none
package bpa_pkg;
    localparam int ROOT_ORDER = 10;
    localparam int ADDR_W     = ROOT_ORDER + 1;
    localparam int TREE_NODES = (1 << (ROOT_ORDER + 1)) - 1;
    localparam int ORD_W      = 4;
    localparam int CNT_W      = 11;
    localparam int PAGE_W     = 44;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 48;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_RANGE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;
endpackage
`default_nettype wire

// ----- hw/rtl/buddy_page_allocator.sv -----
// Buddy page allocator: sequencer over a single-port tree memory.
// Allocation walks down the tree level by level, then updates each parent on the way up to the root;
// an aligned free walks up the same way; a range free repeats it for each set bit of the page count.
// Throughput: one request at a time; s_tready returns the cycle after the result is loaded.
// Reset: synchronous active-low; a clearing pass then writes all 2047 nodes to zero,
// during which s_tready stays low.
`default_nettype none
module buddy_page_allocator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bpa_pkg::PAGE_W-1:0]    cfg_wr_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // tdata: page_count[10:0], page_number[54:11], block_order[58:55], zero fill
    input  wire logic [bpa_pkg::S_DATA_W-1:0]  s_tdata,
    // tuser: req_type[1:0]
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // tdata: granted_page[43:0], zero fill
    output logic [bpa_pkg::M_DATA_W-1:0]       m_tdata,
    // tuser: status[1:0]
    output logic [1:0]                         m_tuser
);
    localparam int R  = bpa_pkg::ROOT_ORDER;
    localparam int AW = bpa_pkg::ADDR_W;
    localparam int OW = bpa_pkg::ORD_W;
    localparam int PW = bpa_pkg::PAGE_W;
    localparam int CW = bpa_pkg::CNT_W;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_A_ROOT, S_A_ROOTCHK, S_A_CHK, S_A_SPL_L, S_A_SPL_R,
        S_A_RD_L, S_A_RD_R, S_A_SEL, S_LEAF, S_U_CHK, S_U_RL, S_U_RR, S_U_W,
        S_F_START, S_F_CHK, S_F_END, S_R_SCAN, S_R_ADV, S_DONE
    } state_t;

    state_t         state_reg, state_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [PW-1:0]  base_reg;
    logic [CW-1:0]  count_reg, count_next;
    logic [PW-1:0]  ppn_reg, ppn_next;
    logic [OW-1:0]  order_reg, order_next;
    logic [OW-1:0]  rounded_reg, rounded_next;
    logic [OW-1:0]  size_reg, size_next;
    logic [OW-1:0]  v_reg, v_next;
    logic [OW-1:0]  lv_reg, lv_next;
    logic [OW-1:0]  lvl_reg, lvl_next;
    logic [OW-1:0]  i_reg, i_next;
    logic [AW-1:0]  nd_reg, nd_next;
    logic           merge_reg, merge_next;
    logic           range_reg, range_next;
    logic [1:0]     status_reg, status_next;
    logic [PW-1:0]  granted_reg, granted_next;
    logic           m_valid_reg, m_valid_next;
    logic [1:0]     m_status_reg, m_status_next;
    logic [PW-1:0]  m_granted_reg, m_granted_next;

    logic [OW-1:0]  tree_mem [bpa_pkg::TREE_NODES];
    logic [OW-1:0]  mem_q;
    logic           mem_we;
    logic [AW-1:0]  mem_addr;
    logic [OW-1:0]  mem_wd;

    logic [CW-1:0]  in_count, nm1;
    logic [OW-1:0]  kbits;
    logic [AW-1:0]  lchild, rchild, fidx, first_node, offset;
    logic [PW-1:0]  pos;
    logic [OW-1:0]  mn, wval;
    logic           bad_free;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tree_mem[mem_addr] <= mem_wd;
        end
        mem_q <= tree_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
        end else if (cfg_wr_en) begin
            base_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        in_count = s_tdata[CW-1:0];
        nm1      = (in_count == '0) ? '0 : in_count - 1'b1;
        kbits    = '0;
        for (int b = 0; b < CW; b++) begin
            if (nm1[b]) kbits = OW'(b + 1);
        end
        lchild     = AW'({nd_reg, 1'b0} + 1'b1);
        rchild     = AW'({nd_reg, 1'b0} + 2'd2);
        pos        = ppn_reg - base_reg;
        bad_free   = (order_reg > OW'(R)) || (pos[PW-1:R] != '0);
        fidx       = AW'(((AW'(1) << (OW'(R) - order_reg)) - 1'b1)
                         + (AW'(pos[R-1:0]) >> order_reg));
        first_node = AW'(1) << (OW'(R + 1) - rounded_reg);
        offset     = AW'((nd_reg + 1'b1 - first_node) << (rounded_reg - 1'b1));
        mn         = (lv_reg < mem_q) ? lv_reg : mem_q;
        if (merge_reg && lv_reg == mem_q && lv_reg == lvl_reg) begin
            wval = lvl_reg + 1'b1;
        end else begin
            wval = (lv_reg > mem_q) ? lv_reg : mem_q;
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        ppn_next       = ppn_reg;
        order_next     = order_reg;
        rounded_next   = rounded_reg;
        size_next      = size_reg;
        v_next         = v_reg;
        lv_next        = lv_reg;
        lvl_next       = lvl_reg;
        i_next         = i_reg;
        nd_next        = nd_reg;
        merge_next     = merge_reg;
        range_next     = range_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_granted_next = m_granted_reg;
        mem_we         = 1'b0;
        mem_addr       = nd_reg;
        mem_wd         = '0;
        s_tready       = 1'b0;

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(bpa_pkg::TREE_NODES - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    count_next   = in_count;
                    ppn_next     = s_tdata[CW+PW-1:CW];
                    order_next   = s_tdata[CW+PW+OW-1:CW+PW];
                    rounded_next = kbits + 1'b1;
                    status_next  = bpa_pkg::ST_OK;
                    granted_next = '0;
                    range_next   = 1'b0;
                    merge_next   = 1'b1;
                    unique case (s_tuser)
                        bpa_pkg::REQ_ALLOC: begin
                            merge_next = 1'b0;
                            state_next = S_A_ROOT;
                        end
                        bpa_pkg::REQ_FREE:  state_next = S_F_START;
                        bpa_pkg::REQ_RANGE: begin
                            range_next = 1'b1;
                            i_next     = OW'(R);
                            state_next = S_R_SCAN;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_A_ROOT: begin
                mem_addr   = '0;
                state_next = S_A_ROOTCHK;
            end
            S_A_ROOTCHK: begin
                if (mem_q < rounded_reg) begin
                    status_next = bpa_pkg::ST_NO_FIT;
                    state_next  = S_DONE;
                end else begin
                    v_next     = mem_q;
                    nd_next    = '0;
                    size_next  = OW'(R + 1);
                    state_next = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (size_reg == rounded_reg) begin
                    if (v_reg == size_reg) begin
                        granted_next = base_reg + PW'(offset);
                        state_next   = S_LEAF;
                    end else begin
                        status_next = bpa_pkg::ST_NO_FIT;
                        state_next  = S_DONE;
                    end
                end else if (v_reg == size_reg) begin
                    state_next = S_A_SPL_L;
                end else begin
                    state_next = S_A_RD_L;
                end
            end
            S_A_SPL_L: begin
                mem_we     = 1'b1;
                mem_addr   = lchild;
                mem_wd     = size_reg - 1'b1;
                state_next = S_A_SPL_R;
            end
            S_A_SPL_R: begin
                // split: both halves free, descend left
                mem_we     = 1'b1;
                mem_addr   = rchild;
                mem_wd     = size_reg - 1'b1;
                nd_next    = lchild;
                v_next     = size_reg - 1'b1;
                size_next  = size_reg - 1'b1;
                state_next = S_A_CHK;
            end
            S_A_RD_L: begin
                mem_addr   = lchild;
                state_next = S_A_RD_R;
            end
            S_A_RD_R: begin
                mem_addr   = rchild;
                lv_next    = mem_q;
                state_next = S_A_SEL;
            end
            S_A_SEL: begin
                // prefer the smaller child that still fits, else the larger one
                if ((mn >= rounded_reg) ? (lv_reg < mem_q) : (lv_reg > mem_q)) begin
                    nd_next = lchild;
                    v_next  = lv_reg;
                end else begin
                    nd_next = rchild;
                    v_next  = mem_q;
                end
                size_next  = size_reg - 1'b1;
                state_next = S_A_CHK;
            end
            S_LEAF: begin
                mem_we     = 1'b1;
                mem_addr   = nd_reg;
                mem_wd     = '0;
                state_next = S_U_CHK;
            end
            S_U_CHK: begin
                if (nd_reg == '0) begin
                    state_next = merge_reg ? S_F_END : S_DONE;
                end else begin
                    nd_next    = (nd_reg - 1'b1) >> 1;
                    state_next = S_U_RL;
                end
            end
            S_U_RL: begin
                mem_addr   = lchild;
                state_next = S_U_RR;
            end
            S_U_RR: begin
                mem_addr   = rchild;
                lv_next    = mem_q;
                state_next = S_U_W;
            end
            S_U_W: begin
                mem_we     = 1'b1;
                mem_addr   = nd_reg;
                mem_wd     = wval;
                lvl_next   = lvl_reg + 1'b1;
                state_next = S_U_CHK;
            end
            S_F_START: begin
                if (bad_free) begin
                    status_next = bpa_pkg::ST_BAD_FREE;
                    state_next  = S_F_END;
                end else begin
                    mem_addr   = fidx;
                    nd_next    = fidx;
                    state_next = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (mem_q != '0) begin
                    status_next = bpa_pkg::ST_BAD_FREE;
                    state_next  = S_F_END;
                end else begin
                    mem_we     = 1'b1;
                    mem_addr   = nd_reg;
                    mem_wd     = order_reg + 1'b1;
                    lvl_next   = order_reg + 1'b1;
                    state_next = S_U_CHK;
                end
            end
            S_F_END: begin
                state_next = range_reg ? S_R_ADV : S_DONE;
            end
            S_R_SCAN: begin
                if (count_reg[i_reg]) begin
                    order_next = i_reg;
                    state_next = S_F_START;
                end else if (i_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    i_next = i_reg - 1'b1;
                end
            end
            S_R_ADV: begin
                ppn_next = ppn_reg + (PW'(1) << i_reg);
                if (i_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    i_next     = i_reg - 1'b1;
                    state_next = S_R_SCAN;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = status_reg;
                    m_granted_next = (status_reg == bpa_pkg::ST_OK) ? granted_reg : '0;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
        count_reg     <= count_next;
        ppn_reg       <= ppn_next;
        order_reg     <= order_next;
        rounded_reg   <= rounded_next;
        size_reg      <= size_next;
        v_reg         <= v_next;
        lv_reg        <= lv_next;
        lvl_reg       <= lvl_next;
        i_reg         <= i_next;
        nd_reg        <= nd_next;
        merge_reg     <= merge_next;
        range_reg     <= range_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
        m_status_reg  <= m_status_next;
        m_granted_reg <= m_granted_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(bpa_pkg::M_DATA_W - PW){1'b0}}, m_granted_reg};
endmodule
`default_nettype wire

// ----- hw/rtl/bpa_checker.sv -----
// Port-level checks of the buddy page allocator, bound to the top level.
`default_nettype none
module bpa_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [bpa_pkg::M_DATA_W-1:0]  m_tdata,
    input wire logic [1:0]                    m_tuser
);
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !s_tready))
        else $error("outputs active right after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready while a request is in work");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == bpa_pkg::ST_OK || m_tuser == bpa_pkg::ST_NO_FIT
                      || m_tuser == bpa_pkg::ST_BAD_FREE))
        else $error("unknown status code");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != bpa_pkg::ST_OK) |-> (m_tdata == '0))
        else $error("granted page set on a failed request");
endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
